FILE: rtl/assert_macros.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QAT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer assertion failed");

// The condition must never hold outside reset.
`define QAT_ASSERT_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tokenizer assertion failed");

`endif

FILE: rtl/qat_pkg.sv
// Types and constants shared by the tokenizer modules.
package qat_pkg;

    localparam int NUM_DELIMS = 4;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_DELIM_A = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DELIM_B = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DELIM_C = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DELIM_D = 3'd3;

    localparam logic [7:0] DELIM_A_RESET = 8'd32;
    localparam logic [7:0] DELIM_B_RESET = 8'd9;
    localparam logic [7:0] DELIM_C_RESET = 8'd13;
    localparam logic [7:0] DELIM_D_RESET = 8'd10;

    localparam logic [7:0] QUOTE_BYTE = 8'h22;
    localparam logic [7:0] BACKSLASH_BYTE = 8'h5C;
    localparam logic [7:0] NUL_BYTE = 8'h00;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_TOKEN_END = 2'd1;
    localparam logic [1:0] KIND_STRING_END = 2'd2;

    localparam logic [1:0] PHASE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_TOKEN = 2'd1;
    localparam logic [1:0] PHASE_QUOTED = 2'd2;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       string_done;
        logic       last_of_run;
    } result_t;

    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } entry_t;

    function automatic result_t make_result(logic [7:0] b, logic [1:0] k, logic d);
        result_t r;
        r.out_byte = b;
        r.kind = k;
        r.string_done = d;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

FILE: rtl/qat_in_if.sv
// Input channel carrying one text byte per word.
interface qat_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;

    modport source (output valid, output char_byte, input ready);
    modport sink (input valid, input char_byte, output ready);
endinterface

FILE: rtl/qat_out_if.sv
// Output channel carrying one token result per word.
interface qat_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       string_done;
    logic       last_of_run;

    modport source (output valid, output out_byte, output kind, output string_done,
                    output last_of_run, input ready);
    modport sink (input valid, input out_byte, input kind, input string_done,
                  input last_of_run, output ready);
endinterface

FILE: rtl/qat_front.sv
// Front end: accepts text bytes, tracks the token state and builds result entries.
module qat_front import qat_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    qat_in_if.sink                 text,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   queue_full,
    output logic                   push,
    output entry_t                 push_entry
);

    logic [7:0] delim_reg [NUM_DELIMS];
    logic [1:0] phase_reg, phase_next;
    logic       mtq_reg, mtq_next;
    logic       esc_reg, esc_next;
    logic       cqp_reg, cqp_next;

    logic       accept;
    logic [7:0] c;
    logic       is_delim;
    logic [1:0] ph;
    logic [1:0] cnt;
    logic       run_tok;
    result_t    res [2];

    assign text.ready = !queue_full;
    assign accept = text.valid && !queue_full;
    assign c = text.char_byte;

    always_comb
    begin
        is_delim = 1'b0;
        for (int i = 0; i < NUM_DELIMS; i++)
        begin
            if (delim_reg[i] != NUL_BYTE && delim_reg[i] == c)
            begin
                is_delim = 1'b1;
            end
        end
    end

    always_comb
    begin
        ph = (phase_reg == PHASE_IDLE || phase_reg == PHASE_TOKEN ||
              phase_reg == PHASE_QUOTED) ? phase_reg : PHASE_IDLE;
        phase_next = ph;
        mtq_next = mtq_reg;
        esc_next = esc_reg;
        cqp_next = cqp_reg;
        cnt = 2'd0;
        run_tok = 1'b0;
        res[0] = make_result(NUL_BYTE, KIND_BYTE, 1'b0);
        res[1] = make_result(NUL_BYTE, KIND_BYTE, 1'b0);

        if (esc_reg)
        begin
            esc_next = 1'b0;
            if (c == NUL_BYTE)
            begin
                if (ph == PHASE_IDLE)
                begin
                    res[cnt[0]] = make_result(NUL_BYTE, KIND_STRING_END, 1'b1);
                end
                else
                begin
                    res[cnt[0]] = make_result(NUL_BYTE, KIND_TOKEN_END, 1'b1);
                end
                cnt = cnt + 2'd1;
                phase_next = PHASE_IDLE;
                mtq_next = 1'b0;
                cqp_next = 1'b0;
            end
            else
            begin
                res[cnt[0]] = make_result(c, KIND_BYTE, 1'b0);
                cnt = cnt + 2'd1;
                if (ph == PHASE_IDLE)
                begin
                    phase_next = PHASE_TOKEN;
                end
            end
        end
        else if (cqp_reg)
        begin
            cqp_next = 1'b0;
            if (c == QUOTE_BYTE)
            begin
                res[cnt[0]] = make_result(QUOTE_BYTE, KIND_BYTE, 1'b0);
                cnt = cnt + 2'd1;
            end
            else
            begin
                if (mtq_reg)
                begin
                    res[cnt[0]] = make_result(QUOTE_BYTE, KIND_BYTE, 1'b0);
                    cnt = cnt + 2'd1;
                end
                phase_next = PHASE_TOKEN;
                run_tok = 1'b1;
            end
        end
        else if (ph == PHASE_IDLE)
        begin
            if (c == NUL_BYTE)
            begin
                res[cnt[0]] = make_result(NUL_BYTE, KIND_STRING_END, 1'b1);
                cnt = cnt + 2'd1;
                phase_next = PHASE_IDLE;
                mtq_next = 1'b0;
            end
            else if (c == QUOTE_BYTE)
            begin
                mtq_next = 1'b0;
                phase_next = PHASE_QUOTED;
            end
            else if (c == BACKSLASH_BYTE)
            begin
                mtq_next = 1'b0;
                esc_next = 1'b1;
            end
            else if (!is_delim)
            begin
                mtq_next = 1'b0;
                res[cnt[0]] = make_result(c, KIND_BYTE, 1'b0);
                cnt = cnt + 2'd1;
                phase_next = PHASE_TOKEN;
            end
        end
        else if (ph == PHASE_TOKEN)
        begin
            run_tok = 1'b1;
        end
        else
        begin
            if (c == NUL_BYTE)
            begin
                res[cnt[0]] = make_result(NUL_BYTE, KIND_TOKEN_END, 1'b1);
                cnt = cnt + 2'd1;
                phase_next = PHASE_IDLE;
                mtq_next = 1'b0;
            end
            else if (c == QUOTE_BYTE)
            begin
                cqp_next = 1'b1;
            end
            else if (c == BACKSLASH_BYTE)
            begin
                esc_next = 1'b1;
            end
            else
            begin
                res[cnt[0]] = make_result(c, KIND_BYTE, 1'b0);
                cnt = cnt + 2'd1;
            end
        end

        if (run_tok)
        begin
            if (c == NUL_BYTE || (c != BACKSLASH_BYTE && c != QUOTE_BYTE && is_delim))
            begin
                res[cnt[0]] = make_result(NUL_BYTE, KIND_TOKEN_END, c == NUL_BYTE);
                cnt = cnt + 2'd1;
                phase_next = PHASE_IDLE;
                mtq_next = 1'b0;
                esc_next = 1'b0;
                cqp_next = 1'b0;
            end
            else if (c == BACKSLASH_BYTE)
            begin
                esc_next = 1'b1;
            end
            else if (c == QUOTE_BYTE)
            begin
                mtq_next = 1'b1;
                res[cnt[0]] = make_result(QUOTE_BYTE, KIND_BYTE, 1'b0);
                cnt = cnt + 2'd1;
                phase_next = PHASE_QUOTED;
            end
            else
            begin
                res[cnt[0]] = make_result(c, KIND_BYTE, 1'b0);
                cnt = cnt + 2'd1;
            end
        end

        if (cnt == 2'd1)
        begin
            res[0].last_of_run = 1'b1;
        end
        if (cnt == 2'd2)
        begin
            res[1].last_of_run = 1'b1;
        end
    end

    assign push = accept && (cnt != 2'd0);
    assign push_entry.two = cnt[1];
    assign push_entry.first = res[0];
    assign push_entry.second = res[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_IDLE;
            mtq_reg <= 1'b0;
            esc_reg <= 1'b0;
            cqp_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            mtq_reg <= mtq_next;
            esc_reg <= esc_next;
            cqp_reg <= cqp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg[0] <= DELIM_A_RESET;
            delim_reg[1] <= DELIM_B_RESET;
            delim_reg[2] <= DELIM_C_RESET;
            delim_reg[3] <= DELIM_D_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DELIM_A: delim_reg[0] <= cfg_data;
                REG_DELIM_B: delim_reg[1] <= cfg_data;
                REG_DELIM_C: delim_reg[2] <= cfg_data;
                REG_DELIM_D: delim_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

FILE: rtl/qat_queue.sv
// Two-entry queue that decouples the front end from the result sequencer.
module qat_queue import qat_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output entry_t head,
    output logic   full,
    output logic   empty
);

    entry_t     store_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

FILE: rtl/qat_back.sv
// Back end: hands the results of each queue entry to the output register in order.
module qat_back import qat_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  entry_t   head,
    input  logic     empty,
    output logic     pop,
    qat_out_if.source token
);

    logic    valid_reg;
    logic    sub_reg;
    result_t out_reg;
    logic    can_load;
    logic    load;

    assign can_load = !valid_reg || token.ready;
    assign load = can_load && !empty;
    assign pop = load && (sub_reg || !head.two);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sub_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= !empty;
            if (load)
            begin
                sub_reg <= !pop;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= sub_reg ? head.second : head.first;
        end
    end

    assign token.valid = valid_reg;
    assign token.out_byte = out_reg.out_byte;
    assign token.kind = out_reg.kind;
    assign token.string_done = out_reg.string_done;
    assign token.last_of_run = out_reg.last_of_run;

endmodule

FILE: rtl/quote_aware_tokenizer.sv
// Top level of the quote-aware text tokenizer.
// The text channel takes one byte per word; a zero byte ends the string.
// The token channel gives one result per word: a token byte, a token end or a
// string end, with string_done on the result of the zero byte and last_of_run
// on the final result of each input byte. Some bytes give no result, some two.
// Delimiters are written through cfg_we, cfg_index and cfg_data; the user
// must write them only while idle, as the block does not enforce it. A byte
// is accepted every cycle while the two-entry queue has room. The front end
// updates the token state in the accepting cycle; each result passes through
// the queue and then the output register, the second, if any, after the first.
// The sustained rate is one result per cycle while the receiver is ready, set
// by the output register. When the receiver stalls, the output register holds
// and the queue fills, after which text.ready falls. Reset empties the queue
// and output, clears the token state and restores the default delimiters.
module quote_aware_tokenizer import qat_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    qat_in_if.sink                 text,
    qat_out_if.source              token,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    `include "assert_macros.svh"

    logic   push;
    entry_t push_entry;
    logic   pop;
    entry_t head;
    logic   queue_full;
    logic   queue_empty;

    qat_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    qat_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (queue_full),
        .empty      (queue_empty)
    );

    qat_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .empty (queue_empty),
        .pop   (pop),
        .token (token)
    );

    `QAT_ASSERT_IMP(a_mark_byte_zero, clk, rst_n, token.valid && token.kind != KIND_BYTE, token.out_byte == NUL_BYTE)
    `QAT_ASSERT_IMP(a_done_is_last_mark, clk, rst_n, token.valid && token.string_done, token.last_of_run && token.kind != KIND_BYTE)
    `QAT_ASSERT_NEVER(a_kind_legal, clk, rst_n, token.valid && token.kind != KIND_BYTE && token.kind != KIND_TOKEN_END && token.kind != KIND_STRING_END)
    `QAT_ASSERT_NEVER(a_full_blocks_input, clk, rst_n, queue_full && text.ready)

endmodule

FILE: tb/sv/tb_quote_aware_tokenizer.sv
// Testbench for the quote-aware tokenizer: directed and random text checked against a token predictor.
module tb_quote_aware_tokenizer;
    timeunit 1ns;
    timeprecision 1ps;

    import qat_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT = 20000;
    localparam int NUM_MIXES = 4;
    localparam int SEND_IDLE[NUM_MIXES] = '{0, 45, 0, 22};
    localparam int RECV_STALL[NUM_MIXES] = '{0, 0, 45, 22};
    localparam logic [7:0] DEFAULT_DELIMS[NUM_DELIMS] =
        '{DELIM_A_RESET, DELIM_B_RESET, DELIM_C_RESET, DELIM_D_RESET};

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    qat_in_if  text_if();
    qat_out_if token_if();

    quote_aware_tokenizer i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .text     (text_if),
        .token    (token_if),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    logic [7:0] delim_copy[NUM_DELIMS];
    logic [1:0] token_phase_q;
    logic       keep_quotes;
    logic       escape_armed;
    logic       quote_close_armed;

    result_t expected_tokens[$];
    result_t step_tokens[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int n_items = 0;
    int n_strings = 0;
    int n_results = 0;
    int n_settings = 0;
    int n_errors = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("[quote_aware_tokenizer] ERROR");
        $finish;
    end

    function automatic bit is_delimiter(input logic [7:0] c);
        foreach (delim_copy[i])
            if (delim_copy[i] != NUL_BYTE && delim_copy[i] == c)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic void add_token(input logic [7:0] b, input logic [1:0] k, input logic d);
        result_t r;
        r.out_byte = b;
        r.kind = k;
        r.string_done = d;
        r.last_of_run = 1'b0;
        step_tokens.push_back(r);
    endfunction

    function automatic void clear_token_state();
        token_phase_q = PHASE_IDLE;
        keep_quotes = 1'b0;
        escape_armed = 1'b0;
        quote_close_armed = 1'b0;
    endfunction

    function automatic void close_token(input logic done);
        add_token(NUL_BYTE, KIND_TOKEN_END, done);
        clear_token_state();
    endfunction

    function automatic void token_byte(input logic [7:0] c);
        if (c == NUL_BYTE)
            close_token(1'b1);
        else if (c == BACKSLASH_BYTE)
            escape_armed = 1'b1;
        else if (c == QUOTE_BYTE)
        begin
            keep_quotes = 1'b1;
            add_token(QUOTE_BYTE, KIND_BYTE, 1'b0);
            token_phase_q = PHASE_QUOTED;
        end
        else if (is_delimiter(c))
            close_token(1'b0);
        else
            add_token(c, KIND_BYTE, 1'b0);
    endfunction

    // Updates the token state for one accepted byte and queues the words it gives.
    function automatic void predict_tokens(input logic [7:0] c);
        step_tokens.delete();
        if (token_phase_q > PHASE_QUOTED)
            token_phase_q = PHASE_IDLE;
        if (escape_armed)
        begin
            escape_armed = 1'b0;
            if (c == NUL_BYTE)
            begin
                if (token_phase_q == PHASE_IDLE)
                begin
                    add_token(NUL_BYTE, KIND_STRING_END, 1'b1);
                    clear_token_state();
                end
                else
                    close_token(1'b1);
            end
            else
            begin
                add_token(c, KIND_BYTE, 1'b0);
                if (token_phase_q == PHASE_IDLE)
                    token_phase_q = PHASE_TOKEN;
            end
        end
        else if (quote_close_armed)
        begin
            quote_close_armed = 1'b0;
            if (c == QUOTE_BYTE)
                add_token(QUOTE_BYTE, KIND_BYTE, 1'b0);
            else
            begin
                if (keep_quotes)
                    add_token(QUOTE_BYTE, KIND_BYTE, 1'b0);
                token_phase_q = PHASE_TOKEN;
                token_byte(c);
            end
        end
        else if (token_phase_q == PHASE_IDLE)
        begin
            if (c == NUL_BYTE)
            begin
                add_token(NUL_BYTE, KIND_STRING_END, 1'b1);
                clear_token_state();
            end
            else if (c == QUOTE_BYTE)
            begin
                keep_quotes = 1'b0;
                token_phase_q = PHASE_QUOTED;
            end
            else if (c == BACKSLASH_BYTE)
            begin
                keep_quotes = 1'b0;
                escape_armed = 1'b1;
            end
            else if (!is_delimiter(c))
            begin
                keep_quotes = 1'b0;
                add_token(c, KIND_BYTE, 1'b0);
                token_phase_q = PHASE_TOKEN;
            end
        end
        else if (token_phase_q == PHASE_TOKEN)
            token_byte(c);
        else
        begin
            if (c == NUL_BYTE)
                close_token(1'b1);
            else if (c == QUOTE_BYTE)
                quote_close_armed = 1'b1;
            else if (c == BACKSLASH_BYTE)
                escape_armed = 1'b1;
            else
                add_token(c, KIND_BYTE, 1'b0);
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
        foreach (step_tokens[i])
            expected_tokens.push_back(step_tokens[i]);
    endfunction

    initial
    begin
        token_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            token_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && token_if.valid && token_if.ready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $error("unexpected token word: out_byte %0d kind %0d",
                           token_if.out_byte, token_if.kind);
                    n_errors++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    n_results++;
                    if (token_if.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %0d, got %0d", want.out_byte,
                               token_if.out_byte);
                        n_errors++;
                    end
                    if (token_if.kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, token_if.kind);
                        n_errors++;
                    end
                    if (token_if.string_done !== want.string_done)
                    begin
                        $error("string_done: expected %0d, got %0d", want.string_done,
                               token_if.string_done);
                        n_errors++;
                    end
                    if (token_if.last_of_run !== want.last_of_run)
                    begin
                        $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                               token_if.last_of_run);
                        n_errors++;
                    end
                end
            end
        end
    end

    task automatic send_char(input logic [7:0] c);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            text_if.valid <= 1'b0;
            @(negedge clk);
        end
        text_if.valid <= 1'b1;
        text_if.char_byte <= c;
        do @(posedge clk); while (!text_if.ready);
        predict_tokens(c);
        n_items++;
        if (c == NUL_BYTE)
            n_strings++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic drain_tokens(input int limit);
        int waited;
        waited = 0;
        @(negedge clk);
        text_if.valid <= 1'b0;
        while (expected_tokens.size() != 0 && waited < limit)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx < NUM_DELIMS)
            delim_copy[idx] = val;
    endtask

    task automatic load_delimiters(input logic [7:0] a, b, c, d);
        drain_tokens(DRAIN_LIMIT);
        write_reg(REG_DELIM_A, a);
        write_reg(REG_DELIM_B, b);
        write_reg(REG_DELIM_C, c);
        write_reg(REG_DELIM_D, d);
        n_settings++;
    endtask

    function automatic logic [7:0] pick_plain();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255));
        while (c == QUOTE_BYTE || c == BACKSLASH_BYTE || is_delimiter(c));
        return c;
    endfunction

    function automatic logic [7:0] pick_delimiter_value();
        case ($urandom_range(0, 7))
            0: return NUL_BYTE;
            1: return 8'hFF;
            2: return 8'h01;
            3: return QUOTE_BYTE;
            4: return BACKSLASH_BYTE;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic send_delim();
        logic [7:0] usable[$];
        foreach (delim_copy[i])
            if (delim_copy[i] != NUL_BYTE && delim_copy[i] != QUOTE_BYTE &&
                delim_copy[i] != BACKSLASH_BYTE)
                usable.push_back(delim_copy[i]);
        if (usable.size() != 0)
            send_char(usable[$urandom_range(usable.size() - 1)]);
    endtask

    task automatic send_plain(input int count);
        repeat (count) send_char(pick_plain());
    endtask

    task automatic send_quoted_body();
        repeat ($urandom_range(0, 4))
        begin
            case ($urandom_range(0, 4))
                0:
                begin
                    send_char(QUOTE_BYTE);
                    send_char(QUOTE_BYTE);
                end
                1: send_delim();
                2:
                begin
                    send_char(BACKSLASH_BYTE);
                    send_char(8'($urandom_range(1, 255)));
                end
                3: send_char(8'($urandom_range(1, 255)));
                default: send_char(pick_plain());
            endcase
        end
    endtask

    task automatic send_wellformed_string();
        repeat ($urandom_range(0, 3))
        begin
            repeat ($urandom_range(0, 2)) send_delim();
            case ($urandom_range(0, 3))
                0: send_plain($urandom_range(1, 4));
                1:
                begin
                    send_char(QUOTE_BYTE);
                    send_quoted_body();
                    send_char(QUOTE_BYTE);
                    send_plain($urandom_range(0, 2));
                end
                2:
                begin
                    send_plain($urandom_range(1, 2));
                    send_char(QUOTE_BYTE);
                    send_quoted_body();
                    send_char(QUOTE_BYTE);
                    send_plain($urandom_range(0, 2));
                end
                default:
                begin
                    send_plain($urandom_range(0, 1));
                    send_char(BACKSLASH_BYTE);
                    send_char(8'($urandom_range(1, 255)));
                    send_plain($urandom_range(0, 2));
                end
            endcase
            send_delim();
        end
        if ($urandom_range(0, 7) == 0)
            send_char($urandom_range(0, 1) ? QUOTE_BYTE : BACKSLASH_BYTE);
        send_char(NUL_BYTE);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 12))
        begin
            case ($urandom_range(0, 5))
                0: send_char(QUOTE_BYTE);
                1: send_char(BACKSLASH_BYTE);
                2: send_delim();
                default: send_char(8'($urandom_range(1, 255)));
            endcase
        end
        if ($urandom_range(0, 3) != 0)
            send_char(NUL_BYTE);
    endtask

    task automatic send_random_strings(input int count);
        int start;
        start = n_items;
        while (n_items - start < count)
        begin
            if ($urandom_range(0, 29) == 0)
                drain_tokens(DRAIN_LIMIT);
            if ($urandom_range(0, 4) == 0)
                send_noise();
            else
                send_wellformed_string();
        end
    endtask

    task automatic test_special_cases();
        send_text(" \"a\"\"b\"");
        send_char(NUL_BYTE);
        send_text("x\"y\"");
        send_char(NUL_BYTE);
        send_char(QUOTE_BYTE);
        send_char(NUL_BYTE);
        send_char(BACKSLASH_BYTE);
        send_char(NUL_BYTE);
        send_char(8'hFF);
        send_char(BACKSLASH_BYTE);
        send_char(NUL_BYTE);
        send_char(DELIM_D_RESET);
        send_char(DELIM_C_RESET);
        send_char(8'h01);
        send_text("\t");
        send_char(NUL_BYTE);
    endtask

    task automatic test_spare_indexes();
        load_delimiters(DEFAULT_DELIMS[0], DEFAULT_DELIMS[1], DEFAULT_DELIMS[2],
                        DEFAULT_DELIMS[3]);
        for (int i = NUM_DELIMS; i < 2 ** CFG_INDEX_W; i++)
            write_reg(CFG_INDEX_W'(i), QUOTE_BYTE);
        send_random_strings(60);
    endtask

    task automatic test_quote_delimiters();
        load_delimiters(QUOTE_BYTE, BACKSLASH_BYTE, NUL_BYTE, 8'hFF);
        send_random_strings(100);
        load_delimiters(NUL_BYTE, NUL_BYTE, NUL_BYTE, NUL_BYTE);
        send_random_strings(50);
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < NUM_MIXES; p++)
        begin
            send_idle_pct = SEND_IDLE[p];
            recv_stall_pct = RECV_STALL[p];
            load_delimiters(DEFAULT_DELIMS[0], DEFAULT_DELIMS[1], DEFAULT_DELIMS[2],
                            DEFAULT_DELIMS[3]);
            send_random_strings(100);
            load_delimiters(pick_delimiter_value(), pick_delimiter_value(),
                            pick_delimiter_value(), pick_delimiter_value());
            send_random_strings(100);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        text_if.valid = 1'b0;
        text_if.char_byte = '0;
        delim_copy = DEFAULT_DELIMS;
        clear_token_state();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_special_cases();
        test_spare_indexes();
        test_quote_delimiters();
        test_random_traffic();

        drain_tokens(DRAIN_LIMIT);
        if (expected_tokens.size() != 0)
        begin
            $error("%0d expected token words never arrived", expected_tokens.size());
            n_errors++;
        end
        $display("Sent %0d text bytes in %0d strings and checked %0d token words,",
                 n_items, n_strings, n_results);
        $display("over %0d delimiter settings and four sender/receiver idle mixes.",
                 n_settings);
        if (n_errors == 0)
            $display("[quote_aware_tokenizer] OK");
        else
            $display("[quote_aware_tokenizer] ERROR");
        $finish;
    end

endmodule
